// ===== rtl/core/grrf_pkg.sv =====
// Shared constants, types and helpers for the gateway request and report framer.
package grrf_pkg;

    localparam int WORD_W   = 44;
    localparam int DIGITS   = 14;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CNT_W    = 6;
    localparam int MEAS_W   = 30;
    localparam int SGL_W    = 32;

    localparam logic [7:0] SYNC_BYTE   = 8'h55;
    localparam logic [7:0] REPORT_HEAD = 8'hAA;
    localparam logic [7:0] REPORT_TAG  = 8'h01;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;

    localparam logic [1:0] CMD_RX     = 2'd0;
    localparam logic [1:0] CMD_MULTI  = 2'd1;
    localparam logic [1:0] CMD_SINGLE = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [7:0] code;
    } rx_status_t;

    function automatic logic [9:0] tri_val(input logic [3:0] d2, input logic [3:0] d1,
                                           input logic [3:0] d0);
        logic [9:0] v;
        v = 10'(d2) * 10'd100 + 10'(d1) * 10'd10 + 10'(d0);
        return v;
    endfunction

    function automatic logic [7:0] pair_val(input logic [3:0] d1, input logic [3:0] d0);
        logic [7:0] v;
        v = 8'(d1) * 8'd10 + 8'(d0);
        return v;
    endfunction

endpackage

// ===== rtl/core/grrf_rx.sv =====
// Request frame receiver: stores frame bytes, checks sync and checksum, latches the code.
module grrf_rx
    import grrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_en,
    input  logic [7:0] rx_byte,
    input  logic       clear,
    input  logic [2:0] rd_idx,
    output logic [7:0] rd_data,
    output rx_status_t status
);

    logic [7:0] rb_reg [8];
    logic [7:0] rb_next [8];
    logic [3:0] pos_reg, pos_next;
    logic [7:0] pend_reg, pend_next;
    logic [7:0] sum_reg, sum_next;
    logic       ok_reg, ok_next;

    always_comb
    begin
        rb_next   = rb_reg;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        sum_next  = sum_reg;
        ok_next   = 1'b0;
        if (clear)
        begin
            for (int i = 0; i < 8; i++)
                rb_next[i] = 8'd0;
            pos_next  = 4'd0;
            pend_next = 8'd0;
            sum_next  = 8'd0;
        end
        else if (rx_en && pend_reg == 8'd0)
        begin
            if (pos_reg == 4'd0 && rx_byte != SYNC_BYTE)
            begin
                for (int i = 0; i < 8; i++)
                    rb_next[i] = 8'd0;
                pos_next = 4'd0;
                sum_next = 8'd0;
            end
            else
            begin
                rb_next[pos_reg[2:0]] = rx_byte;
                pos_next = pos_reg + 4'd1;
                if (pos_reg == 4'd7)
                begin
                    if (sum_reg != rx_byte || rb_reg[1] == 8'd0)
                    begin
                        for (int i = 0; i < 8; i++)
                            rb_next[i] = 8'd0;
                        pos_next = 4'd0;
                        sum_next = 8'd0;
                    end
                    else
                    begin
                        pend_next = rb_reg[1];
                        ok_next   = 1'b1;
                    end
                end
                else
                begin
                    sum_next = sum_reg + rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                rb_reg[i] <= 8'd0;
            pos_reg  <= 4'd0;
            pend_reg <= 8'd0;
            sum_reg  <= 8'd0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            rb_reg   <= rb_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            sum_reg  <= sum_next;
            ok_reg   <= ok_next;
        end
    end

    assign rd_data     = rb_reg[rd_idx];
    assign status.ok   = ok_reg;
    assign status.code = pend_reg;

endmodule

// ===== rtl/core/grrf_b2d.sv =====
// Bit-serial binary to BCD converter, one input bit per cycle.
module grrf_b2d
    import grrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] word,
    output logic              busy,
    output logic [BCD_W-1:0]  bcd
);

    logic [WORD_W-1:0] src_reg;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [BCD_W-1:0]  adj;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
        bcd_next = {adj[BCD_W-2:0], src_reg[WORD_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= '0;
            bcd_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            src_reg  <= word;
            bcd_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_reg <= bcd_next;
            src_reg <= {src_reg[WORD_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
                busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== rtl/core/gateway_request_and_report_framer_core.sv =====
// Top level of the gateway request and report framer.
// A received byte (cmd 0) passes through the S_RX state, and through S_NOTE to one output
// byte when it completes a valid frame. A report converts each measurement word to decimal
// through one shared bit-serial converter and sends one byte per cycle whenever the output
// is free and no conversion runs; a four-record report converts five words, a single-record
// one two. The input is taken again only when the previous request has finished.
module gateway_request_and_report_framer_core
    import grrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [7:0]        rx_byte,
    input  logic [MEAS_W-1:0] pressure_word,
    input  logic [WORD_W-1:0] glucose_record_1,
    input  logic [WORD_W-1:0] glucose_record_2,
    input  logic [WORD_W-1:0] glucose_record_3,
    input  logic [WORD_W-1:0] glucose_record_4,
    input  logic [SGL_W-1:0]  single_glucose_word,
    input  logic              force_bad_checksum,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [7:0]        tx_byte,
    output logic [7:0]        request_code,
    output logic              final_byte
);

    typedef enum logic [2:0] {S_IDLE, S_RX, S_NOTE, S_HDR, S_CONV, S_EMIT, S_SUM} state_t;
    typedef enum logic [1:0] {K_REC, K_PRS, K_SGL} kind_t;

    state_t            state_reg;
    logic [2:0]        k_reg;
    logic [2:0]        wi_reg;
    logic              go_reg;
    logic              multi_reg;
    logic              force_reg;
    logic [7:0]        sum_reg;
    logic [WORD_W-1:0] g_reg [4];
    logic [MEAS_W-1:0] m_reg;
    logic [SGL_W-1:0]  w_reg;
    logic              out_valid_reg;
    logic              kind_reg;
    logic [7:0]        tx_reg;
    logic [7:0]        code_reg;
    logic              final_reg;

    logic              slot;
    logic              emit;
    logic              in_acc;
    logic              rx_en;
    logic              rx_clear;
    logic [7:0]        rd_data;
    rx_status_t        rx_st;
    logic              conv_start;
    logic [WORD_W-1:0] conv_word;
    logic              conv_busy;
    logic [BCD_W-1:0]  bcd;
    kind_t             kind;
    logic [2:0]        last_k;
    logic [7:0]        hdr_byte;
    logic [7:0]        emit_byte;
    logic [9:0]        t_hi, t_mid, t_lo, t_gl;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign slot       = !out_valid_reg || out_ready;
    assign emit       = slot && (state_reg inside {S_NOTE, S_HDR, S_EMIT, S_SUM});
    assign rx_en      = in_acc && cmd == CMD_RX;
    assign rx_clear   = (state_reg == S_SUM) && slot;
    assign conv_start = (state_reg == S_CONV) && go_reg;

    always_comb
    begin
        if (multi_reg)
            kind = (wi_reg == 3'd4) ? K_PRS : K_REC;
        else
            kind = (wi_reg == 3'd0) ? K_SGL : K_PRS;
        case (kind)
            K_REC:   last_k = 3'd6;
            K_PRS:   last_k = 3'd5;
            default: last_k = 3'd1;
        endcase
        case (kind)
            K_REC:   conv_word = g_reg[wi_reg[1:0]];
            K_SGL:   conv_word = WORD_W'(w_reg);
            default: conv_word = WORD_W'(m_reg);
        endcase
    end

    always_comb
    begin
        case (k_reg)
            3'd0:    hdr_byte = REPORT_HEAD;
            3'd1:    hdr_byte = REPORT_TAG;
            3'd7:    hdr_byte = BYTE_ZERO;
            default: hdr_byte = rd_data;
        endcase
    end

    always_comb
    begin
        t_gl  = tri_val(bcd[51:48], bcd[47:44], bcd[43:40]);
        t_hi  = tri_val(bcd[35:32], bcd[31:28], bcd[27:24]);
        t_mid = tri_val(bcd[23:20], bcd[19:16], bcd[15:12]);
        t_lo  = tri_val(bcd[11:8], bcd[7:4], bcd[3:0]);
        emit_byte = BYTE_ZERO;
        case (kind)
            K_REC:
            begin
                case (k_reg)
                    3'd0:    emit_byte = {6'd0, t_gl[9:8]};
                    3'd1:    emit_byte = t_gl[7:0];
                    3'd2:    emit_byte = pair_val(bcd[39:36], bcd[35:32]);
                    3'd3:    emit_byte = pair_val(bcd[31:28], bcd[27:24]);
                    3'd4:    emit_byte = pair_val(bcd[23:20], bcd[19:16]);
                    3'd5:    emit_byte = pair_val(bcd[15:12], bcd[11:8]);
                    3'd6:    emit_byte = pair_val(bcd[7:4], bcd[3:0]);
                    default: emit_byte = BYTE_ZERO;
                endcase
            end
            K_PRS:
            begin
                case (k_reg)
                    3'd0:    emit_byte = {6'd0, t_hi[9:8]};
                    3'd1:    emit_byte = t_hi[7:0];
                    3'd2:    emit_byte = {6'd0, t_mid[9:8]};
                    3'd3:    emit_byte = t_mid[7:0];
                    3'd4:    emit_byte = {6'd0, t_lo[9:8]};
                    3'd5:    emit_byte = t_lo[7:0];
                    default: emit_byte = BYTE_ZERO;
                endcase
            end
            default:
            begin
                case (k_reg)
                    3'd0:    emit_byte = {6'd0, t_hi[9:8]};
                    3'd1:    emit_byte = t_hi[7:0];
                    default: emit_byte = BYTE_ZERO;
                endcase
            end
        endcase
    end

    grrf_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_en   (rx_en),
        .rx_byte (rx_byte),
        .clear   (rx_clear),
        .rd_idx  (k_reg),
        .rd_data (rd_data),
        .status  (rx_st)
    );

    grrf_b2d u_b2d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .word  (conv_word),
        .busy  (conv_busy),
        .bcd   (bcd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 3'd0;
            wi_reg        <= 3'd0;
            go_reg        <= 1'b0;
            multi_reg     <= 1'b0;
            force_reg     <= 1'b0;
            sum_reg       <= 8'd0;
            for (int i = 0; i < 4; i++)
                g_reg[i] <= '0;
            m_reg         <= '0;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            tx_reg        <= 8'd0;
            code_reg      <= 8'd0;
            final_reg     <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        g_reg[0]  <= glucose_record_1;
                        g_reg[1]  <= glucose_record_2;
                        g_reg[2]  <= glucose_record_3;
                        g_reg[3]  <= glucose_record_4;
                        m_reg     <= pressure_word;
                        w_reg     <= single_glucose_word;
                        force_reg <= force_bad_checksum;
                        multi_reg <= (cmd == CMD_MULTI);
                        k_reg     <= 3'd0;
                        wi_reg    <= 3'd0;
                        sum_reg   <= 8'd0;
                        case (cmd)
                            CMD_RX:     state_reg <= S_RX;
                            CMD_MULTI:  state_reg <= S_HDR;
                            CMD_SINGLE: state_reg <= S_HDR;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_RX:
                begin
                    state_reg <= rx_st.ok ? S_NOTE : S_IDLE;
                end
                S_NOTE:
                begin
                    if (slot)
                    begin
                        kind_reg      <= 1'b1;
                        tx_reg        <= 8'd0;
                        code_reg      <= rx_st.code;
                        final_reg     <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_HDR:
                begin
                    if (slot)
                    begin
                        kind_reg      <= 1'b0;
                        tx_reg        <= hdr_byte;
                        code_reg      <= 8'd0;
                        final_reg     <= 1'b0;
                        sum_reg       <= sum_reg + hdr_byte;
                        if (k_reg == 3'd7)
                        begin
                            k_reg     <= 3'd0;
                            go_reg    <= 1'b1;
                            state_reg <= S_CONV;
                        end
                        else
                        begin
                            k_reg <= k_reg + 3'd1;
                        end
                    end
                end
                S_CONV:
                begin
                    go_reg <= 1'b0;
                    if (!go_reg && !conv_busy)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot)
                    begin
                        kind_reg      <= 1'b0;
                        tx_reg        <= emit_byte;
                        code_reg      <= 8'd0;
                        final_reg     <= 1'b0;
                        sum_reg       <= sum_reg + emit_byte;
                        if (k_reg == last_k)
                        begin
                            k_reg <= 3'd0;
                            if (kind == K_PRS)
                            begin
                                state_reg <= S_SUM;
                            end
                            else
                            begin
                                wi_reg    <= wi_reg + 3'd1;
                                go_reg    <= 1'b1;
                                state_reg <= S_CONV;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 3'd1;
                        end
                    end
                end
                S_SUM:
                begin
                    if (slot)
                    begin
                        kind_reg      <= 1'b0;
                        tx_reg        <= sum_reg + {7'd0, force_reg & multi_reg};
                        code_reg      <= 8'd0;
                        final_reg     <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign tx_byte      = tx_reg;
    assign request_code = code_reg;
    assign final_byte   = final_reg;

endmodule

// ===== rtl/core/grrf_checker.sv =====
// Port-level checker for the framer core, bound to the top level.
module grrf_checker
    import grrf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        cmd,
    input logic [7:0]        rx_byte,
    input logic [MEAS_W-1:0] pressure_word,
    input logic [WORD_W-1:0] glucose_record_1,
    input logic [WORD_W-1:0] glucose_record_2,
    input logic [WORD_W-1:0] glucose_record_3,
    input logic [WORD_W-1:0] glucose_record_4,
    input logic [SGL_W-1:0]  single_glucose_word,
    input logic              force_bad_checksum,
    input logic              out_valid,
    input logic              out_ready,
    input logic              result_kind,
    input logic [7:0]        tx_byte,
    input logic [7:0]        request_code,
    input logic              final_byte
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(final_byte))
        else $error("request output changed while stalled");

    a_notice_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> final_byte && tx_byte == 8'd0 && request_code != 8'd0)
        else $error("malformed request notice");

    a_report_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> request_code == 8'd0)
        else $error("report byte carries a request code");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_RX || cmd == CMD_MULTI || cmd == CMD_SINGLE)
        |=> !in_ready)
        else $error("input ready right after accepting a request");

endmodule

bind gateway_request_and_report_framer_core grrf_checker u_grrf_checker (.*);

// ===== tb/gateway_request_and_report_framer_core_test.sv =====
// Testbench for the gateway request and report framer: table-driven and random requests
// checked byte by byte against a behavioral model of frame reception and report building.
`timescale 1ns / 1ps
module gateway_request_and_report_framer_core_test;
    import grrf_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic [7:0] code;
        logic       last;
    } report_byte_t;

    typedef struct {
        logic [1:0]        cmd;
        logic [7:0]        rx;
        logic [MEAS_W-1:0] pw;
        logic [WORD_W-1:0] g1;
        logic [WORD_W-1:0] g2;
        logic [WORD_W-1:0] g3;
        logic [WORD_W-1:0] g4;
        logic [SGL_W-1:0]  sg;
        logic              fb;
    } framer_request_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        cmd;
    logic [7:0]        rx_byte;
    logic [MEAS_W-1:0] pressure_word;
    logic [WORD_W-1:0] glucose_record_1;
    logic [WORD_W-1:0] glucose_record_2;
    logic [WORD_W-1:0] glucose_record_3;
    logic [WORD_W-1:0] glucose_record_4;
    logic [SGL_W-1:0]  single_glucose_word;
    logic              force_bad_checksum;
    logic              out_valid;
    logic              out_ready;
    logic              result_kind;
    logic [7:0]        tx_byte;
    logic [7:0]        request_code;
    logic              final_byte;

    gateway_request_and_report_framer_core dut (.*);

    logic [7:0] rx_frame [8];
    int         rx_pos;
    logic [7:0] held_code;

    report_byte_t    pending_bytes [$];
    framer_request_t table_rows [$];
    report_byte_t    typed_bytes [$];
    bit              row_typed [$];
    int              errors;
    int              idle_pct;
    int              stall_pct;
    bit              hold_off;
    longint          cycle_count;
    bit              sent_all;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        errors++;
    endtask

    function automatic void clear_frame();
        for (int i = 0; i < 8; i++) rx_frame[i] = 8'h00;
        rx_pos = 0;
        held_code = 8'h00;
    endfunction

    task automatic push_report(input logic [7:0] buf_b [43], input int len, input int extra);
        logic [15:0] sum;
        sum = 0;
        for (int i = 0; i < len - 1; i++) sum += buf_b[i];
        buf_b[len-1] = 8'(sum + extra);
        for (int i = 0; i < len; i++)
            pending_bytes.push_back('{1'b0, buf_b[i], 8'h00, i == len - 1});
        clear_frame();
    endtask

    task automatic predict_request(input framer_request_t r);
        logic [7:0] b [43];
        logic [15:0] sum;
        longint unsigned w, gt, m;
        int at;
        m = 64'(r.pw);
        for (int i = 0; i < 43; i++) b[i] = 8'h00;
        b[0] = REPORT_HEAD; b[1] = REPORT_TAG;
        for (int i = 0; i < 5; i++) b[2+i] = rx_frame[2+i];
        if (r.cmd == CMD_RX) begin
            if (held_code != 0) return;
            if (rx_pos == 0 && r.rx != SYNC_BYTE) begin
                clear_frame();
                return;
            end
            rx_frame[rx_pos] = r.rx;
            rx_pos++;
            if (rx_pos < 8) return;
            sum = 0;
            for (int i = 0; i < 7; i++) sum += rx_frame[i];
            if (sum[7:0] != r.rx || rx_frame[1] == 0) begin
                clear_frame();
                return;
            end
            held_code = rx_frame[1];
            pending_bytes.push_back('{1'b1, 8'h00, held_code, 1'b1});
        end else if (r.cmd == CMD_MULTI) begin
            for (int i = 0; i < 4; i++) begin
                w = 64'((i == 0) ? r.g1 : (i == 1) ? r.g2 : (i == 2) ? r.g3 : r.g4);
                gt = w % 64'd10000000000;
                at = 8 + i * 7;
                b[at]   = 8'(((w / 64'd10000000000) % 1000) >> 8);
                b[at+1] = 8'((w / 64'd10000000000) % 1000);
                b[at+2] = 8'((gt / 100000000) % 100);
                b[at+3] = 8'((gt / 1000000) % 100);
                b[at+4] = 8'((gt / 10000) % 100);
                b[at+5] = 8'((gt / 100) % 100);
                b[at+6] = 8'(gt % 100);
            end
            b[36] = 8'(((m / 1000000) % 1000) >> 8); b[37] = 8'((m / 1000000) % 1000);
            b[38] = 8'(((m / 1000) % 1000) >> 8);    b[39] = 8'((m / 1000) % 1000);
            b[40] = 8'((m % 1000) >> 8);             b[41] = 8'(m % 1000);
            push_report(b, 43, r.fb);
        end else if (r.cmd == CMD_SINGLE) begin
            w = 64'(r.sg);
            b[8]  = 8'(((w / 1000000) % 1000) >> 8); b[9]  = 8'((w / 1000000) % 1000);
            b[10] = 8'(((m / 1000000) % 1000) >> 8); b[11] = 8'((m / 1000000) % 1000);
            b[12] = 8'(((m / 1000) % 1000) >> 8);    b[13] = 8'((m / 1000) % 1000);
            b[14] = 8'((m % 1000) >> 8);             b[15] = 8'(m % 1000);
            push_report(b, 17, 0);
        end
    endtask

    function automatic framer_request_t rand_request();
        framer_request_t r;
        r.cmd = 2'($urandom_range(0, 3));
        r.rx  = 8'($urandom);
        r.pw  = ($urandom_range(0, 3) == 0) ? MEAS_W'($urandom) : MEAS_W'($urandom_range(0, 999999999));
        r.g1  = WORD_W'({$urandom, $urandom});
        r.g2  = ($urandom_range(0, 1)) ? WORD_W'({$urandom, $urandom}) : WORD_W'(64'd9999999999999);
        r.g3  = WORD_W'({$urandom, $urandom}) % WORD_W'(64'd10000000000000);
        r.g4  = WORD_W'({$urandom, $urandom});
        r.sg  = $urandom;
        r.fb  = 1'($urandom);
        return r;
    endfunction

    function automatic framer_request_t rx_request(input logic [7:0] v);
        framer_request_t r;
        r = rand_request();
        r.cmd = CMD_RX;
        r.rx = v;
        return r;
    endfunction

    task automatic queue_frame(input logic [7:0] code, input bit corrupt);
        logic [7:0] f [8];
        logic [7:0] s;
        f[0] = SYNC_BYTE; f[1] = code; s = SYNC_BYTE + code;
        for (int i = 2; i < 7; i++) begin
            f[i] = 8'($urandom);
            s += f[i];
        end
        f[7] = corrupt ? s + 8'(1 + $urandom_range(0, 254)) : s;
        for (int i = 0; i < 8; i++) begin
            table_rows.push_back(rx_request(f[i]));
            row_typed.push_back(0);
        end
    endtask

    task automatic send_request(input framer_request_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= r.cmd; rx_byte <= r.rx; pressure_word <= r.pw;
        glucose_record_1 <= r.g1; glucose_record_2 <= r.g2;
        glucose_record_3 <= r.g3; glucose_record_4 <= r.g4;
        single_glucose_word <= r.sg; force_bad_checksum <= r.fb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_request(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 64'd1500000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("unexpected tx_byte", tx_byte, 8'h00);
            end
            else
            begin
                report_byte_t e;
                e = pending_bytes.pop_front();
                if (result_kind !== e.kind)
                    report_mismatch("result_kind", {7'd0, result_kind}, {7'd0, e.kind});
                if (tx_byte !== e.tx) report_mismatch("tx_byte", tx_byte, e.tx);
                if (request_code !== e.code) report_mismatch("request_code", request_code, e.code);
                if (final_byte !== e.last)
                    report_mismatch("final_byte", {7'd0, final_byte}, {7'd0, e.last});
            end
        end
    end

    initial
    begin
        framer_request_t r;
        int n;
        errors = 0; idle_pct = 0; stall_pct = 0; hold_off = 0; sent_all = 0;
        rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
        cmd = CMD_RX; rx_byte = 0; pressure_word = 0;
        glucose_record_1 = 0; glucose_record_2 = 0; glucose_record_3 = 0; glucose_record_4 = 0;
        single_glucose_word = 0; force_bad_checksum = 0;
        clear_frame();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: single report after reset is fully known
        r = rand_request();
        r.cmd = CMD_SINGLE; r.sg = 0; r.pw = 0;
        table_rows.push_back(r); row_typed.push_back(1);
        for (int i = 0; i < 17; i++)
            typed_bytes.push_back('{1'b0, (i == 0) ? REPORT_HEAD : (i == 1) ? REPORT_TAG :
                                   (i == 16) ? 8'hAB : 8'h00, 8'h00, i == 16});
        r.cmd = CMD_MULTI; r.g1 = WORD_W'(64'd9999999999999); r.g2 = '1; r.g3 = 0; r.g4 = 0;
        r.pw = MEAS_W'(999999999); r.fb = 1;
        table_rows.push_back(r); row_typed.push_back(0);
        r.cmd = 2'd3;
        table_rows.push_back(r); row_typed.push_back(0);
        table_rows.push_back(rx_request(8'h00)); row_typed.push_back(0);
        table_rows.push_back(rx_request(8'hFF)); row_typed.push_back(0);
        queue_frame(8'hFF, 0);
        table_rows.push_back(rx_request(SYNC_BYTE)); row_typed.push_back(0);
        r = rand_request(); r.cmd = CMD_MULTI; r.fb = 1;
        table_rows.push_back(r); row_typed.push_back(0);

        foreach (table_rows[i])
        begin
            if (row_typed[i])
            begin
                send_request(table_rows[i]);
                void'(pending_bytes.size());
                pending_bytes.delete();
                foreach (typed_bytes[j]) pending_bytes.push_back(typed_bytes[j]);
            end
            else
                send_request(table_rows[i]);
        end
        table_rows.delete();
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 54) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 54) : 0;
            n = 0;
            while (n < 100)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: queue_frame(8'($urandom_range(0, 3) == 0 ? 0 : $urandom),
                                            $urandom_range(0, 4) == 0);
                    4, 5, 6: begin
                        r = rand_request();
                        r.cmd = ($urandom_range(0, 2) == 0) ? CMD_MULTI : CMD_SINGLE;
                        table_rows.push_back(r);
                    end
                    default: table_rows.push_back(rand_request());
                endcase
                while (table_rows.size() != 0)
                begin
                    send_request(table_rows.pop_front());
                    n++;
                end
                row_typed.delete();
            end
            if (ph == 0)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (2000) @(negedge clk);
                        hold_off = 0;
                    end
                    begin
                        for (int k = 0; k < 6; k++)
                        begin
                            r = rand_request();
                            r.cmd = CMD_MULTI;
                            send_request(r);
                        end
                    end
                join
            end
            wait_drained();
        end

        if (errors == 0 && pending_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
